FILE: rtl/psuct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the rectifier telemetry/setpoint engine.
// No dependencies; imported by psu_can_telemetry_and_setpoint.
package psuct_pkg;

  localparam int DEF_SETPOINT_SLOTS = 4;
  localparam int DEF_TABLE_ENTRIES  = 12;
  localparam int DEF_READABLE       = 10;

  localparam logic [28:0] TELEMETRY_ID  = 29'h1081407F;
  localparam logic [28:0] SETVALUE_ID   = 29'h108180FE;
  localparam logic [28:0] REQUEST_ID    = 29'h108040FE;
  localparam int          EXT_FLAG_BIT  = 31;
  localparam logic [3:0]  FRAME_LEN_FULL = 4'd8;
  localparam logic [15:0] INTERVAL_RESET = 16'd250;
  localparam logic [7:0]  SETVALUE_CMD   = 8'h01;

  localparam logic [7:0] CODE_GRP0_LO = 8'h70;
  localparam logic [7:0] CODE_GRP0_HI = 8'h76;
  localparam logic [7:0] CODE_SLOT7   = 8'h78;
  localparam logic [7:0] CODE_SLOT8   = 8'h7F;
  localparam logic [7:0] CODE_GRP1_LO = 8'h80;
  localparam logic [7:0] CODE_GRP1_HI = 8'h82;
  localparam logic [7:0] CODE_COMPLETE = 8'h81;
  localparam logic [3:0] SLOT7        = 4'd7;
  localparam logic [3:0] SLOT8        = 4'd8;
  localparam logic [3:0] GRP1_BASE    = 4'd9;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_SETVALUE = 2'd1;
  localparam logic [1:0] KIND_REQUEST  = 2'd2;
  localparam logic [1:0] KIND_READ     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_REQ,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [3:0]  param_index;
    logic [15:0] param_value;
    logic        clear_complete;
    logic        clear_errors;
    logic        tx_ok;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [28:0] tx_id;
    logic [63:0] tx_data;
    logic [31:0] read_value;
    logic        complete_flag;
    logic        error_rx;
    logic        error_tx;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } slot_map_t;

  function automatic slot_map_t map_code(logic [7:0] code);
    slot_map_t m;
    m.hit  = 1'b1;
    m.slot = '0;
    case (code) inside
      [CODE_GRP0_LO:CODE_GRP0_HI]: m.slot = 4'(code - CODE_GRP0_LO);
      CODE_SLOT7:                  m.slot = SLOT7;
      CODE_SLOT8:                  m.slot = SLOT8;
      [CODE_GRP1_LO:CODE_GRP1_HI]: m.slot = 4'(code - CODE_GRP1_LO) + GRP1_BASE;
      default:                     m.hit  = 1'b0;
    endcase
    return m;
  endfunction

  function automatic out_beat_t mk_beat(logic [1:0] kind, logic [28:0] id,
                                        logic [63:0] data, logic [31:0] rv,
                                        logic comp, logic erx, logic etx,
                                        logic lst);
    out_beat_t b;
    b.out_kind      = kind;
    b.tx_id         = id;
    b.tx_data       = data;
    b.read_value    = rv;
    b.complete_flag = comp;
    b.error_rx      = erx;
    b.error_tx      = etx;
    b.last          = lst;
    return b;
  endfunction

endpackage

FILE: rtl/psu_can_telemetry_and_setpoint.sv
`timescale 1ns / 1ps
// Rectifier CAN telemetry decode, setpoint queue and periodic request engine.
// Depends on psuct_pkg (beat structs, codes, state enum, slot map).
//
//   channel | signals                  | handshake
//   --------+--------------------------+-------------------------------------
//   input   | in_beat                  | accepted when start && !busy
//   result  | out_beat                 | out_strobe, one cycle, no stall
//   config  | cfg_wdata (interval)     | written when cfg_we
//
// Frame, write and read beats are captured, then executed and emitted.
// A tick is captured and executed, then the slot walker visits each setpoint
// slot in turn, then the request countdown is stepped and finally the held
// result is flushed. Tick results leave through a one-deep hold register.
// Synchronous reset clears the table, pending bits, flags and countdown.
// The receiver cannot stall; results are lost if not taken on the strobe.
module psu_can_telemetry_and_setpoint #(
  parameter int NUM_SETPOINT_SLOTS = psuct_pkg::DEF_SETPOINT_SLOTS,
  parameter int NUM_TABLE_ENTRIES  = psuct_pkg::DEF_TABLE_ENTRIES,
  parameter int READABLE_ENTRIES   = psuct_pkg::DEF_READABLE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  psuct_pkg::in_beat_t  in_beat,
  output logic                 out_strobe,
  output psuct_pkg::out_beat_t out_beat,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import psuct_pkg::*;

  localparam int SW = (NUM_SETPOINT_SLOTS > 1) ? $clog2(NUM_SETPOINT_SLOTS) : 1;
  localparam int TW = $clog2(NUM_TABLE_ENTRIES);

  state_t      state_r, state_nxt;
  in_beat_t    in_r, in_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [15:0] interval_r;
  logic [15:0] countdown_r, countdown_nxt;
  logic        comp_r, comp_nxt;
  logic        err_rx_r, err_rx_nxt;
  logic        err_tx_r, err_tx_nxt;
  logic [31:0] value_tab_r [NUM_TABLE_ENTRIES];
  logic [15:0] sp_value_r [NUM_SETPOINT_SLOTS];
  logic [NUM_SETPOINT_SLOTS-1:0] sp_pend_r, sp_pend_nxt;
  logic        hold_vld_r, hold_vld_nxt;
  out_beat_t   hold_r, hold_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  out_beat_t   out_r, out_nxt;

  logic          tab_we;
  logic [TW-1:0] tab_wa;
  logic          sp_we;
  slot_map_t     map;
  logic          frame_hit;
  logic          read_ok;
  logic          write_ok;
  logic [31:0]   rd_value;
  out_beat_t     gen;
  logic          gen_vld;

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_beat   = out_r;

  assign map       = map_code(in_r.frame_data[55:48]);
  assign frame_hit = in_r.frame_id[EXT_FLAG_BIT] && (in_r.frame_id[28:0] == TELEMETRY_ID) &&
                     (in_r.frame_len == FRAME_LEN_FULL);
  assign tab_wa    = map.slot[TW-1:0];
  assign read_ok   = ({1'b0, in_r.param_index} < 5'(READABLE_ENTRIES)) &&
                     ({1'b0, in_r.param_index} < 5'(NUM_TABLE_ENTRIES));
  assign write_ok  = ({1'b0, in_r.param_index} < 5'(NUM_SETPOINT_SLOTS));
  assign rd_value  = read_ok ? value_tab_r[in_r.param_index[TW-1:0]] : 32'h0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = (in_r.req_type == REQ_TICK) ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (slot_r == SW'(NUM_SETPOINT_SLOTS - 1)) state_nxt = ST_REQ;
      ST_REQ:   state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_nxt         = in_r;
    slot_nxt       = slot_r;
    countdown_nxt  = countdown_r;
    comp_nxt       = comp_r;
    err_rx_nxt     = err_rx_r;
    err_tx_nxt     = err_tx_r;
    sp_pend_nxt    = sp_pend_r;
    hold_vld_nxt   = hold_vld_r;
    hold_nxt       = hold_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    tab_we         = 1'b0;
    sp_we          = 1'b0;
    gen_vld        = 1'b0;
    gen            = hold_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt       = in_beat;
          slot_nxt     = '0;
          hold_vld_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        case (in_r.req_type)
          REQ_FRAME: begin
            if (frame_hit) begin
              tab_we = map.hit && ({1'b0, map.slot} < 5'(NUM_TABLE_ENTRIES));
              if (in_r.frame_data[55:48] == CODE_COMPLETE) comp_nxt = 1'b1;
            end
            out_strobe_nxt = 1'b1;
            out_nxt = mk_beat(KIND_STATUS, '0, '0, '0, comp_nxt, err_rx_r, err_tx_r, 1'b1);
          end
          REQ_WRITE: begin
            if (write_ok) begin
              sp_we = 1'b1;
              sp_pend_nxt[in_r.param_index[SW-1:0]] = 1'b1;
            end
            out_strobe_nxt = 1'b1;
            out_nxt = mk_beat(KIND_STATUS, '0, '0, '0, comp_r, err_rx_r, err_tx_r, 1'b1);
          end
          REQ_READ: begin
            out_strobe_nxt = 1'b1;
            out_nxt = mk_beat(KIND_READ, '0, '0, rd_value, comp_r, err_rx_r, err_tx_r, 1'b1);
            if (in_r.clear_complete) comp_nxt = 1'b0;
            if (in_r.clear_errors) begin
              err_rx_nxt = 1'b0;
              err_tx_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (sp_pend_r[slot_r]) begin
          if (in_r.tx_ok) begin
            sp_pend_nxt[slot_r] = 1'b0;
            gen_vld = 1'b1;
            gen = mk_beat(KIND_SETVALUE, SETVALUE_ID,
                          {SETVALUE_CMD, 8'(slot_r), 32'h0, sp_value_r[slot_r]},
                          '0, comp_r, err_rx_r, err_tx_r, 1'b0);
          end else begin
            err_tx_nxt = 1'b1;
          end
        end
        slot_nxt = slot_r + SW'(1);
      end
      ST_REQ: begin
        if (countdown_r == 16'h0) begin
          if (in_r.tx_ok) begin
            gen_vld = 1'b1;
            gen = mk_beat(KIND_REQUEST, REQUEST_ID, '0, '0, comp_r, err_rx_r, err_tx_r, 1'b0);
          end else begin
            err_rx_nxt = 1'b1;
          end
          countdown_nxt = interval_r;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
      ST_FLUSH: begin
        out_strobe_nxt = 1'b1;
        hold_vld_nxt   = 1'b0;
        if (hold_vld_r) begin
          out_nxt      = hold_r;
          out_nxt.last = 1'b1;
        end else begin
          out_nxt = mk_beat(KIND_STATUS, '0, '0, '0, comp_r, err_rx_r, err_tx_r, 1'b1);
        end
      end
      default: ;
    endcase
    // a new frame pushes the held one out, not yet last
    if (gen_vld) begin
      out_strobe_nxt = hold_vld_r;
      out_nxt        = hold_r;
      hold_nxt       = gen;
      hold_vld_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      interval_r   <= INTERVAL_RESET;
      countdown_r  <= '0;
      comp_r       <= 1'b0;
      err_rx_r     <= 1'b0;
      err_tx_r     <= 1'b0;
      sp_pend_r    <= '0;
      hold_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NUM_TABLE_ENTRIES; i++) begin
        value_tab_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      countdown_r  <= countdown_nxt;
      comp_r       <= comp_nxt;
      err_rx_r     <= err_rx_nxt;
      err_tx_r     <= err_tx_nxt;
      sp_pend_r    <= sp_pend_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) interval_r <= cfg_wdata;
      if (tab_we) value_tab_r[tab_wa] <= in_r.frame_data[31:0];
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    if (sp_we) sp_value_r[in_r.param_index[SW-1:0]] <= in_r.param_value;
  end

`ifndef ASSERT_OFF
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_beat.last) |-> (state_r == ST_IDLE))
    else $error("last beat while item still in flight");

  a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_beat.last) |-> busy)
    else $error("non-final beat after item finished");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_hold_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (busy && in_r.req_type == REQ_TICK && in_r.tx_ok))
    else $error("held frame outside a tick with bus ok");
`endif

endmodule

FILE: dv/psu_can_telemetry_and_setpoint_test.sv
`timescale 1ns / 1ps
// Self-checking bench for psu_can_telemetry_and_setpoint: a directed stimulus table,
// then random phases at several request intervals; typed rows check a listed beat,
// all else is scored against an in-bench model. Depends on psuct_pkg and the block RTL.
module psu_can_telemetry_and_setpoint_test;
  import psuct_pkg::*;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 89;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_beat_t    in_beat   = '0;
  logic        out_strobe;
  out_beat_t   out_beat;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // engine state as seen by the scoreboard
  logic [15:0] req_interval;
  logic [31:0] tel_values [DEF_TABLE_ENTRIES];
  logic [15:0] sp_value [DEF_SETPOINT_SLOTS];
  bit          sp_pending [DEF_SETPOINT_SLOTS];
  bit          upd_complete;
  bit          err_rx;
  bit          err_tx;
  logic [15:0] req_countdown;

  out_beat_t   step_beats[$];
  out_beat_t   awaited_beats[$];
  stim_row_t   directed_rows[$];
  logic [15:0] intervals [PHASES];
  int          fail_count = 0;
  int          burst_left = 0;

  psu_can_telemetry_and_setpoint dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_beat    (in_beat),
    .out_strobe (out_strobe),
    .out_beat   (out_beat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int tel_slot(logic [7:0] code);
    if (code >= CODE_GRP0_LO && code <= CODE_GRP0_HI) return int'(code - CODE_GRP0_LO);
    if (code == CODE_SLOT7) return int'(SLOT7);
    if (code == CODE_SLOT8) return int'(SLOT8);
    if (code >= CODE_GRP1_LO && code <= CODE_GRP1_HI)
      return int'(code - CODE_GRP1_LO) + int'(GRP1_BASE);
    return -1;
  endfunction

  function automatic void add_beat(logic [1:0] kind, logic [28:0] id, logic [63:0] data,
                                   logic [31:0] rv);
    out_beat_t b;
    b.out_kind      = kind;
    b.tx_id         = id;
    b.tx_data       = data;
    b.read_value    = rv;
    b.complete_flag = upd_complete;
    b.error_rx      = err_rx;
    b.error_tx      = err_tx;
    b.last          = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void engine_step(in_beat_t b);
    int        slot;
    out_beat_t tail;
    step_beats.delete();
    case (b.req_type)
      REQ_FRAME: begin
        if (b.frame_id[EXT_FLAG_BIT] && b.frame_id[28:0] == TELEMETRY_ID &&
            b.frame_len == FRAME_LEN_FULL) begin
          slot = tel_slot(b.frame_data[55:48]);
          if (slot >= 0) tel_values[slot] = b.frame_data[31:0];
          if (b.frame_data[55:48] == CODE_COMPLETE) upd_complete = 1'b1;
        end
        add_beat(KIND_STATUS, '0, '0, '0);
      end
      REQ_WRITE: begin
        if (b.param_index < DEF_SETPOINT_SLOTS) begin
          sp_value[b.param_index]   = b.param_value;
          sp_pending[b.param_index] = 1'b1;
        end
        add_beat(KIND_STATUS, '0, '0, '0);
      end
      REQ_READ: begin
        add_beat(KIND_READ, '0, '0,
                 (b.param_index < DEF_READABLE) ? tel_values[b.param_index] : 32'd0);
        if (b.clear_complete) upd_complete = 1'b0;
        if (b.clear_errors) begin
          err_rx = 1'b0;
          err_tx = 1'b0;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < DEF_SETPOINT_SLOTS; i++) begin
          if (sp_pending[i]) begin
            if (b.tx_ok) begin
              sp_pending[i] = 1'b0;
              add_beat(KIND_SETVALUE, SETVALUE_ID, {SETVALUE_CMD, 8'(i), 32'd0, sp_value[i]},
                       '0);
            end else begin
              err_tx = 1'b1;
            end
          end
        end
        if (req_countdown == 16'd0) begin
          if (b.tx_ok) add_beat(KIND_REQUEST, REQUEST_ID, '0, '0);
          else err_rx = 1'b1;
          req_countdown = req_interval;
        end else begin
          req_countdown = req_countdown - 16'd1;
        end
        if (step_beats.size() == 0) add_beat(KIND_STATUS, '0, '0, '0);
      end
    endcase
    tail = step_beats[step_beats.size() - 1];
    tail.last = 1'b1;
    step_beats[step_beats.size() - 1] = tail;
  endfunction

  function automatic in_beat_t frame_beat(logic [31:0] id, logic [3:0] len, logic [63:0] data);
    in_beat_t b = '0;
    b.req_type   = REQ_FRAME;
    b.frame_id   = id;
    b.frame_len  = len;
    b.frame_data = data;
    return b;
  endfunction

  function automatic in_beat_t write_beat(logic [3:0] idx, logic [15:0] val);
    in_beat_t b = '0;
    b.req_type    = REQ_WRITE;
    b.param_index = idx;
    b.param_value = val;
    return b;
  endfunction

  function automatic in_beat_t read_beat(logic [3:0] idx, logic clr_c, logic clr_e);
    in_beat_t b = '0;
    b.req_type       = REQ_READ;
    b.param_index    = idx;
    b.clear_complete = clr_c;
    b.clear_errors   = clr_e;
    return b;
  endfunction

  function automatic in_beat_t tick_beat(logic ok);
    in_beat_t b = '0;
    b.req_type = REQ_TICK;
    b.tx_ok    = ok;
    return b;
  endfunction

  function automatic void add_row(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    stim_row_t r;
    r.beat  = b;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  // mostly well-formed telemetry frames and in-range slots, the rest broken or noise
  function automatic in_beat_t random_beat();
    logic [127:0] noise;
    in_beat_t     b;
    int           k;
    noise = {$urandom, $urandom, $urandom, $urandom};
    b = noise[$bits(in_beat_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 38) begin
      b.req_type = REQ_FRAME;
      b.frame_id[EXT_FLAG_BIT] = 1'b1;
      b.frame_id[28:0] = TELEMETRY_ID;
      b.frame_len = FRAME_LEN_FULL;
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, 13);
        if (k < 7) b.frame_data[55:48] = CODE_GRP0_LO + 8'(k);
        else if (k == 7) b.frame_data[55:48] = CODE_SLOT7;
        else if (k == 8) b.frame_data[55:48] = CODE_SLOT8;
        else if (k < 12) b.frame_data[55:48] = CODE_GRP1_LO + 8'(k - 9);
      end else begin
        case ($urandom_range(0, 3))
          0: b.frame_id[EXT_FLAG_BIT] = 1'b0;
          1: b.frame_len = 4'($urandom_range(0, 15));
          2: b.frame_id[28:0] = TELEMETRY_ID ^ (29'd1 << $urandom_range(0, 28));
          default: begin
            b.frame_id  = $urandom;
            b.frame_len = 4'($urandom_range(0, 15));
          end
        endcase
      end
    end else if (k < 58) begin
      b.req_type = REQ_WRITE;
      if ($urandom_range(0, 9) != 0)
        b.param_index = 4'($urandom_range(0, DEF_SETPOINT_SLOTS - 1));
    end else if (k < 80) begin
      b.req_type = REQ_READ;
      if ($urandom_range(0, 9) != 0)
        b.param_index = 4'($urandom_range(0, DEF_TABLE_ENTRIES - 1));
      b.clear_complete = ($urandom_range(0, 3) == 0);
      b.clear_errors   = ($urandom_range(0, 3) == 0);
    end else begin
      b.req_type = REQ_TICK;
      b.tx_ok    = ($urandom_range(0, 4) != 0);
    end
    return b;
  endfunction

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drive_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy !== 1'b0);
    engine_step(b);
    if (typed) awaited_beats.push_back(want);
    else foreach (step_beats[j]) awaited_beats.push_back(step_beats[j]);
  endtask

  task automatic report_miss(input string what, input out_beat_t want, input out_beat_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%s @%0t exp: kind %0d id %h data %h rv %h cmp/rx/tx %b%b%b last %b", what,
               $time, want.out_kind, want.tx_id, want.tx_data, want.read_value,
               want.complete_flag, want.error_rx, want.error_tx, want.last);
      $display("%s @%0t got: kind %0d id %h data %h rv %h cmp/rx/tx %b%b%b last %b", what,
               $time, got.out_kind, got.tx_id, got.tx_data, got.read_value,
               got.complete_flag, got.error_rx, got.error_tx, got.last);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (awaited_beats.size() == 0) begin
        report_miss("unexpected beat", '0, out_beat);
      end else begin
        want = awaited_beats.pop_front();
        if (want.out_kind !== out_beat.out_kind || want.tx_id !== out_beat.tx_id ||
            want.tx_data !== out_beat.tx_data || want.read_value !== out_beat.read_value ||
            want.complete_flag !== out_beat.complete_flag ||
            want.error_rx !== out_beat.error_rx || want.error_tx !== out_beat.error_tx ||
            want.last !== out_beat.last)
          report_miss("beat mismatch", want, out_beat);
      end
    end
  end

  initial begin
    req_interval  = INTERVAL_RESET;
    req_countdown = 16'd0;
    upd_complete  = 1'b0;
    err_rx        = 1'b0;
    err_tx        = 1'b0;
    foreach (tel_values[i]) tel_values[i] = 32'd0;
    foreach (sp_value[i]) begin
      sp_value[i]   = 16'd0;
      sp_pending[i] = 1'b0;
    end
    intervals = '{16'd0, 16'($urandom_range(2, 9)), 16'd1, 16'd4, 16'hFFFF};

    add_row(read_beat(4'd0, 1'b0, 1'b0), 1'b1,
            out_beat_t'{KIND_READ, 29'd0, 64'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(tick_beat(1'b0), 1'b1,
            out_beat_t'{KIND_STATUS, 29'd0, 64'd0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(read_beat(4'd0, 1'b0, 1'b1), 1'b1,
            out_beat_t'{KIND_READ, 29'd0, 64'd0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h0070_0000_FFFF_FFFF),
            1'b1, out_beat_t'{KIND_STATUS, 29'd0, 64'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(read_beat(4'd0, 1'b0, 1'b0), 1'b1,
            out_beat_t'{KIND_READ, 29'd0, 64'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(frame_beat({1'b1, 2'b11, TELEMETRY_ID}, FRAME_LEN_FULL, 64'hFF81_FFFF_1234_5678),
            1'b1, out_beat_t'{KIND_STATUS, 29'd0, 64'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h0082_0000_A5A5_A5A5));
    add_row(read_beat(4'd11, 1'b0, 1'b0), 1'b1,
            out_beat_t'{KIND_READ, 29'd0, 64'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(read_beat(4'd15, 1'b1, 1'b0), 1'b1,
            out_beat_t'{KIND_READ, 29'd0, 64'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1});
    add_row(frame_beat({1'b0, 2'b11, TELEMETRY_ID}, FRAME_LEN_FULL, 64'hFF71_FFFF_DEAD_BEEF));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, 4'd7, 64'h0072_0000_0000_1111));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID ^ 29'd1}, FRAME_LEN_FULL,
                       64'h0073_0000_0000_2222));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h0077_0000_0000_3333));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h007F_0000_0000_4444));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h0078_0000_8000_0001));
    add_row(frame_beat({1'b1, 2'b00, TELEMETRY_ID}, FRAME_LEN_FULL, 64'h0080_0000_0000_0000));
    add_row(read_beat(4'd8, 1'b0, 1'b0));
    add_row(read_beat(4'd9, 1'b0, 1'b0));
    add_row(write_beat(4'd0, 16'hFFFF));
    add_row(write_beat(4'd3, 16'h0000));
    add_row(write_beat(4'd4, 16'h1234));
    add_row(write_beat(4'd15, 16'hABCD));
    add_row(tick_beat(1'b0));
    add_row(tick_beat(1'b1));
    add_row(read_beat(4'd7, 1'b1, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      drive_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);

    for (int p = 0; p < PHASES; p++) begin
      start <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clk);
      repeat (16) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= intervals[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      req_interval = intervals[p];
      repeat (PHASE_ITEMS) drive_beat(random_beat(), 1'b0, '0);
    end
    start <= 1'b0;

    for (int g = 0; g < 4000 && awaited_beats.size() != 0; g++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_beats.size() != 0) begin
      fail_count += awaited_beats.size();
      $display("%0d expected beats never arrived", awaited_beats.size());
    end
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/psuct_pkg.sv
rtl/psu_can_telemetry_and_setpoint.sv
dv/psu_can_telemetry_and_setpoint_test.sv
